FILE: rtl/tcdac_pkg.sv
// ---------------------------------------------------------------------------
// tcdac_pkg
// Shared types, register map codes and helper functions of the truecolor
// DAC register block.
// ---------------------------------------------------------------------------
package tcdac_pkg;

  localparam int PALETTE_ENTRIES = 2;
  localparam int PAL_IDX_W       = 8;
  localparam int COLOR_W         = 24;
  localparam int IN_DATA_W       = 24;
  localparam int OUT_DATA_W      = 80;

  // access kind
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // register map
  localparam logic [3:0] ADDR_PASS_LAST = 4'h3;
  localparam logic [3:0] ADDR_PAL_INDEX = 4'h4;
  localparam logic [3:0] ADDR_PAL_DATA  = 4'h5;
  localparam logic [3:0] ADDR_ID_6      = 4'h6;
  localparam logic [3:0] ADDR_ID_8      = 4'h8;
  localparam logic [3:0] ADDR_ID_A      = 4'hA;
  localparam logic [3:0] ADDR_FORMAT    = 4'hB;
  localparam logic [3:0] ADDR_WIDTH     = 4'hC;
  localparam logic [3:0] ADDR_ID_F      = 4'hF;

  // identity bytes
  localparam logic [7:0] ID_REV    = 8'h02;
  localparam logic [7:0] ID_PART   = 8'h1D;
  localparam logic [7:0] ID_VENDOR = 8'hD0;

  // pixel formats
  localparam logic [2:0] FMT_4BPP     = 3'd0;
  localparam logic [2:0] FMT_8BPP     = 3'd1;
  localparam logic [2:0] FMT_15BPP    = 3'd2;
  localparam logic [2:0] FMT_16BPP    = 3'd3;
  localparam logic [2:0] FMT_24BPP    = 3'd4;
  localparam logic [2:0] FMT_32BPP    = 3'd5;
  localparam logic [2:0] FMT_ABGR8888 = 3'd6;
  localparam logic [2:0] FMT_RGBA8888 = 3'd7;

  // per-word result of one access
  typedef struct packed {
    logic [7:0] read_byte;
    logic       fwd_valid;
    logic [1:0] fwd_port;
    logic       fwd_is_write;
    logic [7:0] fwd_byte;
    logic       width_req_valid;
    logic       width_req_six;
  } acc_res_t;

  function automatic logic [2:0] decode_format(input logic [7:0] b);
    logic [2:0] f;
    case (b) inside
      8'h82:        f = FMT_4BPP;
      8'h83:        f = FMT_8BPP;
      8'hA0, 8'hB0: f = FMT_15BPP;
      8'hA1, 8'hB1: f = FMT_16BPP;
      8'hC0, 8'hD0: f = FMT_24BPP;
      8'hE2, 8'hF7: f = FMT_32BPP;
      8'hE3:        f = FMT_ABGR8888;
      8'hF2:        f = FMT_RGBA8888;
      default:      f = FMT_8BPP;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] expand6(input logic [7:0] c);
    return {c[5:0], c[5:4]};
  endfunction

  function automatic logic [COLOR_W-1:0] color_view(input logic [COLOR_W-1:0] v,
                                                    input logic six);
    logic [COLOR_W-1:0] e;
    e = {expand6(v[23:16]), expand6(v[15:8]), expand6(v[7:0])};
    return six ? e : v;
  endfunction

endpackage

FILE: rtl/tcdac_core.sv
// ---------------------------------------------------------------------------
// tcdac_core
// Register file, palette loader and format decode. State updates on each
// accepted word; the per-word result is combinational from the word.
// ---------------------------------------------------------------------------
module tcdac_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        acc_en,
  input  logic                        acc_op,
  input  logic [3:0]                  acc_addr,
  input  logic [7:0]                  acc_wbyte,
  input  logic [7:0]                  acc_vbyte,
  output tcdac_pkg::acc_res_t         acc_res,
  output logic [2:0]                  pixel_format,
  output logic [tcdac_pkg::COLOR_W-1:0] cursor_color0,
  output logic [tcdac_pkg::COLOR_W-1:0] cursor_color1
);
  import tcdac_pkg::*;

  localparam logic [1:0] PH_RED   = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_BLUE  = 2'd2;

  logic [7:0]           reg_file_r   [16];
  logic [7:0]           reg_file_nxt [16];
  logic [PAL_IDX_W-1:0] pal_index_r, pal_index_nxt;
  logic [1:0]           rgb_phase_r, rgb_phase_nxt;
  logic [7:0]           held_red_r, held_red_nxt;
  logic [7:0]           held_green_r, held_green_nxt;
  logic [COLOR_W-1:0]   palette_r   [PALETTE_ENTRIES];
  logic [COLOR_W-1:0]   palette_nxt [PALETTE_ENTRIES];
  logic [2:0]           format_r, format_nxt;
  logic                 six_bit_r;

  logic pass_thru;
  logic is_wr;
  logic pal_in_range;

  assign pass_thru    = (acc_addr <= ADDR_PASS_LAST);
  assign is_wr        = acc_en && !pass_thru && (acc_op == OP_WRITE);
  assign pal_in_range = ({1'b0, pal_index_r} < (PAL_IDX_W+1)'(PALETTE_ENTRIES));

  always_comb begin
    reg_file_nxt   = reg_file_r;
    pal_index_nxt  = pal_index_r;
    rgb_phase_nxt  = rgb_phase_r;
    held_red_nxt   = held_red_r;
    held_green_nxt = held_green_r;
    palette_nxt    = palette_r;
    format_nxt     = format_r;
    if (is_wr) begin
      reg_file_nxt[acc_addr] = acc_wbyte;
      case (acc_addr)
        ADDR_PAL_INDEX: begin
          pal_index_nxt = acc_wbyte;
          rgb_phase_nxt = PH_RED;
        end
        ADDR_PAL_DATA: begin
          case (rgb_phase_r)
            PH_RED: begin
              held_red_nxt  = acc_wbyte;
              rgb_phase_nxt = PH_GREEN;
            end
            PH_GREEN: begin
              held_green_nxt = acc_wbyte;
              rgb_phase_nxt  = PH_BLUE;
            end
            PH_BLUE: begin
              // out-of-range index drops the write and stays in blue
              if (pal_in_range) begin
                for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                  if (pal_index_r == PAL_IDX_W'(i))
                    palette_nxt[i] = {held_red_r, held_green_r, acc_wbyte};
                end
                rgb_phase_nxt = PH_RED;
                pal_index_nxt = pal_index_r + PAL_IDX_W'(1);
              end
            end
            default: ;
          endcase
        end
        ADDR_FORMAT: format_nxt = decode_format(acc_wbyte);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) reg_file_r[i] <= '0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) palette_r[i] <= '0;
      pal_index_r  <= '0;
      rgb_phase_r  <= PH_RED;
      held_red_r   <= '0;
      held_green_r <= '0;
      format_r     <= FMT_8BPP;
      six_bit_r    <= 1'b0;
    end else begin
      reg_file_r   <= reg_file_nxt;
      palette_r    <= palette_nxt;
      pal_index_r  <= pal_index_nxt;
      rgb_phase_r  <= rgb_phase_nxt;
      held_red_r   <= held_red_nxt;
      held_green_r <= held_green_nxt;
      format_r     <= format_nxt;
      if (cfg_we) six_bit_r <= cfg_wdata;
    end
  end

  // per-word result; reads change no state so current contents serve
  always_comb begin
    acc_res = '0;
    if (pass_thru) begin
      acc_res.fwd_valid = 1'b1;
      acc_res.fwd_port  = acc_addr[1:0];
      if (acc_op == OP_READ) begin
        acc_res.read_byte = acc_vbyte;
      end else begin
        acc_res.fwd_is_write = 1'b1;
        acc_res.fwd_byte     = acc_wbyte;
      end
    end else if (acc_op == OP_READ) begin
      case (acc_addr) inside
        ADDR_PAL_INDEX, ADDR_ID_8: acc_res.read_byte = ID_REV;
        ADDR_ID_6, ADDR_ID_A:      acc_res.read_byte = ID_PART;
        ADDR_ID_F:                 acc_res.read_byte = ID_VENDOR;
        default:                   acc_res.read_byte = reg_file_r[acc_addr];
      endcase
    end else if (acc_addr == ADDR_WIDTH) begin
      acc_res.width_req_valid = 1'b1;
      acc_res.width_req_six   = acc_wbyte[0];
    end
  end

  // state holds what the last accepted word left, so these track its result
  assign pixel_format  = format_r;
  assign cursor_color0 = color_view(palette_r[0], six_bit_r);
  assign cursor_color1 = color_view(palette_r[1], six_bit_r);

endmodule

FILE: rtl/truecolor_dac_register_block_top.sv
// ---------------------------------------------------------------------------
// truecolor_dac_register_block_top
// Register block of a truecolor DAC with pass-through VGA DAC ports and a
// two-entry cursor palette.
// ---------------------------------------------------------------------------
// One bus access per input word, one result word per access, one word per
// cycle sustained while out_tready holds high. The register update and result
// mux sit between the input port and a single output register, so a result
// appears the cycle after its access is taken; in_tready stays high while the
// output register is empty or being drained. Palette colors and pixel format
// reflect the state after the access that produced the word.
module truecolor_dac_register_block_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,   // dac_six_bit
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // reg_addr[3:0], write_byte[11:4], vga_read_byte[19:12]
  input  logic [tcdac_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,    // opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // read_byte[7:0], fwd_valid[8], fwd_port[10:9], fwd_is_write[11],
  // fwd_byte[19:12], pixel_format[22:20], cursor_color0[46:23],
  // cursor_color1[70:47], width_req_valid[71], width_req_six[72]
  output logic [tcdac_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tcdac_pkg::*;

  logic               in_acc;
  acc_res_t           acc_res;
  acc_res_t           res_r;
  logic               out_valid_r;
  logic [2:0]         pixel_format;
  logic [COLOR_W-1:0] color0, color1;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  tcdac_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .acc_en        (in_acc),
    .acc_op        (in_tuser),
    .acc_addr      (in_tdata[3:0]),
    .acc_wbyte     (in_tdata[11:4]),
    .acc_vbyte     (in_tdata[19:12]),
    .acc_res       (acc_res),
    .pixel_format  (pixel_format),
    .cursor_color0 (color0),
    .cursor_color1 (color1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) res_r <= acc_res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0,
                       res_r.width_req_six,
                       res_r.width_req_valid,
                       color1,
                       color0,
                       pixel_format,
                       res_r.fwd_byte,
                       res_r.fwd_is_write,
                       res_r.fwd_port,
                       res_r.fwd_valid,
                       res_r.read_byte};

endmodule

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Checks the truecolor DAC register block against a behavioral predictor.
// Every accepted access is run through the predictor. Each result word is
// compared field by field with the oldest prediction. Stimulus is a short
// directed sweep, then random palette sequences, format and width writes
// and noise. Both stream sides get random gaps, and the DAC width setting
// changes between phases while the block is drained.
// ---------------------------------------------------------------------------
module tb;
  import tcdac_pkg::*;

  localparam int TOTAL_ITEMS = 1950;
  localparam int NUM_PHASES  = 8;
  localparam int QUIET_LIMIT = 1000;

  // pass-through ports and plain storage registers without identity bytes
  localparam logic [3:0] ADDR_WR_INDEX = 4'h0;
  localparam logic [3:0] ADDR_DATA     = 4'h1;
  localparam logic [3:0] ADDR_MASK     = 4'h2;
  localparam logic [3:0] ADDR_RD_INDEX = 4'h3;
  localparam logic [3:0] ADDR_PLAIN_7  = 4'h7;

  localparam logic [7:0] FMT_BYTES [12] = '{8'h82, 8'h83, 8'hA0, 8'hB0, 8'hA1, 8'hB1,
                                            8'hC0, 8'hD0, 8'hE2, 8'hF7, 8'hE3, 8'hF2};

  typedef enum logic [1:0] {PH_RED, PH_GREEN, PH_BLUE, PH_UNUSED} rgb_phase_e;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        fwd_valid;
    logic [1:0]  fwd_port;
    logic        fwd_is_write;
    logic [7:0]  fwd_byte;
    logic [2:0]  pixel_format;
    logic [23:0] color0;
    logic [23:0] color1;
    logic        width_req_valid;
    logic        width_req_six;
  } dac_word_t;

  class dac_access_checker;
    logic [7:0]  regs [16];
    logic [7:0]  pal_index;
    rgb_phase_e  phase;
    logic [7:0]  held_red;
    logic [7:0]  held_green;
    logic [23:0] palette [PALETTE_ENTRIES];
    logic [2:0]  format_code;
    logic        six_bit;
    dac_word_t   expected_words [$];
    int          errors;
    int          words_checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (palette[i]) palette[i] = '0;
      pal_index     = '0;
      phase         = PH_RED;
      held_red      = '0;
      held_green    = '0;
      format_code   = FMT_8BPP;
      six_bit       = 1'b0;
      errors        = 0;
      words_checked = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 30) $display("mismatch at word %0d: %s", words_checked, msg);
    endfunction

    function void set_six_bit(logic v);
      six_bit = v;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function logic [2:0] format_of(logic [7:0] b);
      logic [2:0] f;
      case (b)
        8'h82:        f = FMT_4BPP;
        8'h83:        f = FMT_8BPP;
        8'hA0, 8'hB0: f = FMT_15BPP;
        8'hA1, 8'hB1: f = FMT_16BPP;
        8'hC0, 8'hD0: f = FMT_24BPP;
        8'hE2, 8'hF7: f = FMT_32BPP;
        8'hE3:        f = FMT_ABGR8888;
        8'hF2:        f = FMT_RGBA8888;
        default:      f = FMT_8BPP;
      endcase
      return f;
    endfunction

    // 6-bit component stretched to 8 bits by repeating its top bits
    function logic [7:0] widen6(logic [7:0] c);
      return {c[5:0], 2'b00} | {6'b0, c[5:4]};
    endfunction

    function logic [23:0] shown_color(logic [23:0] v);
      if (!six_bit) return v;
      return {widen6(v[23:16]), widen6(v[15:8]), widen6(v[7:0])};
    endfunction

    function void note_access(logic op, logic [3:0] addr, logic [7:0] wb, logic [7:0] vb);
      dac_word_t w;
      w = '0;
      if (addr <= ADDR_PASS_LAST) begin
        w.fwd_valid = 1'b1;
        w.fwd_port  = addr[1:0];
        if (op == OP_READ) begin
          w.read_byte = vb;
        end else begin
          w.fwd_is_write = 1'b1;
          w.fwd_byte     = wb;
        end
      end else if (op == OP_READ) begin
        case (addr)
          ADDR_PAL_INDEX, ADDR_ID_8: w.read_byte = ID_REV;
          ADDR_ID_6, ADDR_ID_A:      w.read_byte = ID_PART;
          ADDR_ID_F:                 w.read_byte = ID_VENDOR;
          default:                   w.read_byte = regs[addr];
        endcase
      end else begin
        regs[addr] = wb;
        case (addr)
          ADDR_PAL_INDEX: begin
            pal_index = wb;
            phase     = PH_RED;
          end
          ADDR_PAL_DATA: begin
            case (phase)
              PH_RED: begin
                held_red = wb;
                phase    = PH_GREEN;
              end
              PH_GREEN: begin
                held_green = wb;
                phase      = PH_BLUE;
              end
              PH_BLUE: begin
                // index past the palette: word dropped, phase stays on blue
                if (pal_index < PALETTE_ENTRIES) begin
                  palette[pal_index] = {held_red, held_green, wb};
                  phase              = PH_RED;
                  pal_index          = pal_index + 8'd1;
                end
              end
              default: ;
            endcase
          end
          ADDR_FORMAT: format_code = format_of(wb);
          ADDR_WIDTH: begin
            w.width_req_valid = 1'b1;
            w.width_req_six   = wb[0];
          end
          default: ;
        endcase
      end
      w.pixel_format = format_code;
      w.color0       = shown_color(palette[0]);
      w.color1       = shown_color(palette[1]);
      expected_words.push_back(w);
    endfunction

    function void same(string field, logic [23:0] got, logic [23:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", field, got, want));
    endfunction

    function void check_word(logic [79:0] d);
      dac_word_t want;
      if (expected_words.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = expected_words.pop_front();
      same("read_byte",       24'(d[7:0]),   24'(want.read_byte));
      same("fwd_valid",       24'(d[8]),     24'(want.fwd_valid));
      same("fwd_port",        24'(d[10:9]),  24'(want.fwd_port));
      same("fwd_is_write",    24'(d[11]),    24'(want.fwd_is_write));
      same("fwd_byte",        24'(d[19:12]), 24'(want.fwd_byte));
      same("pixel_format",    24'(d[22:20]), 24'(want.pixel_format));
      same("cursor_color0",   d[46:23],      want.color0);
      same("cursor_color1",   d[70:47],      want.color1);
      same("width_req_valid", 24'(d[71]),    24'(want.width_req_valid));
      same("width_req_six",   24'(d[72]),    24'(want.width_req_six));
      words_checked++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;     // reg_addr, write_byte, vga_read_byte
  logic        in_tuser   = 1'b0;   // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;           // read_byte .. width_req_six, see dut ports

  dac_access_checker sb = new();
  bit          idling = 1'b1;
  int          items_sent = 0;
  int unsigned quiet_cycles = 0;

  truecolor_dac_register_block_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitors sample pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_six_bit(cfg_wdata);
      if (in_tvalid && in_tready)
        sb.note_access(in_tuser, in_tdata[3:0], in_tdata[11:4], in_tdata[19:12]);
      if (out_tvalid && out_tready) sb.check_word(out_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall bursts between ready runs
  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 30)) @(posedge clk);
    end
  end

  task automatic send_access(input logic op, input logic [3:0] addr,
                             input logic [7:0] wb, input logic [7:0] vb);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, vb, wb, addr};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_six_bit(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_noise();
    send_access(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic run_directed();
    send_access(OP_WRITE, ADDR_WR_INDEX, 8'hFF, 8'h00);
    send_access(OP_READ,  ADDR_WR_INDEX, 8'h00, 8'hFF);
    send_access(OP_WRITE, ADDR_DATA,     8'hA5, 8'h5A);
    send_access(OP_READ,  ADDR_MASK,     8'h00, 8'h5A);
    send_access(OP_WRITE, ADDR_RD_INDEX, 8'h00, 8'hFF);
    send_access(OP_READ,  ADDR_RD_INDEX, 8'hFF, 8'h00);
    // fill both palette entries, then overrun the palette
    send_access(OP_WRITE, ADDR_PAL_INDEX, 8'h00, 8'h00);
    send_access(OP_WRITE, ADDR_PAL_DATA,  8'hFF, 8'h00);
    send_access(OP_WRITE, ADDR_PAL_DATA,  8'h00, 8'h00);
    send_access(OP_WRITE, ADDR_PAL_DATA,  8'h3F, 8'h00);
    send_access(OP_WRITE, ADDR_PAL_DATA,  8'hC0, 8'h00);
    send_access(OP_WRITE, ADDR_PAL_DATA,  8'h80, 8'h00);
    send_access(OP_WRITE, ADDR_PAL_DATA,  8'hFF, 8'h00);
    send_access(OP_WRITE, ADDR_PAL_DATA,  8'h12, 8'h00);
    send_access(OP_WRITE, ADDR_PAL_DATA,  8'h34, 8'h00);
    send_access(OP_WRITE, ADDR_PAL_DATA,  8'h56, 8'h00);
    send_access(OP_WRITE, ADDR_FORMAT,    8'hF2, 8'h00);
    send_access(OP_WRITE, ADDR_FORMAT,    8'h00, 8'h00);
    send_access(OP_WRITE, ADDR_FORMAT,    8'h82, 8'h00);
    send_access(OP_WRITE, ADDR_WIDTH,     8'hFF, 8'h00);
    send_access(OP_WRITE, ADDR_WIDTH,     8'h00, 8'h00);
    send_access(OP_READ,  ADDR_PAL_INDEX, 8'h00, 8'hFF);
    send_access(OP_READ,  ADDR_ID_6,      8'h00, 8'hFF);
    send_access(OP_READ,  ADDR_ID_8,      8'h00, 8'hFF);
    send_access(OP_READ,  ADDR_ID_A,      8'h00, 8'hFF);
    send_access(OP_READ,  ADDR_ID_F,      8'h00, 8'hFF);
    send_access(OP_READ,  ADDR_PAL_DATA,  8'h00, 8'hFF);
    send_access(OP_READ,  ADDR_PLAIN_7,   8'h00, 8'hFF);
  endtask

  task automatic run_random(input int target);
    logic [7:0] idx;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // palette sequence, mostly aimed at a valid entry
          if ($urandom_range(0, 3) != 0) begin
            idx = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 1));
            send_access(OP_WRITE, ADDR_PAL_INDEX, idx, 8'($urandom_range(0, 255)));
          end
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 7) == 0) send_noise();
            send_access(OP_WRITE, ADDR_PAL_DATA, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
          end
        end
        5: send_access(OP_WRITE, ADDR_FORMAT,
                       ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                   : FMT_BYTES[$urandom_range(0, 11)],
                       8'($urandom_range(0, 255)));
        6: send_access(OP_WRITE, ADDR_WIDTH, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        default: send_noise();
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_six_bit(1'b0);
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_six_bit(p[0] == 1'b0);
      // one quiet phase in the middle and one at the end
      idling = (p != 3) && (p != NUM_PHASES - 1);
      run_random((p + 1) * TOTAL_ITEMS / NUM_PHASES);
    end
    drain_results();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
